### design/rws_pkg.sv
package rws_pkg;

    localparam int NUM_TYPES     = 3;
    localparam int REGS_PER_TYPE = 64;
    localparam int LIST_DEPTH    = 8;
    localparam int SEQ_BITS      = 16;

    localparam int TYPE_BITS  = 2;
    localparam int INDEX_BITS = 6;
    localparam int SEQ_W      = 16;
    localparam int REG_AW     = $clog2(REGS_PER_TYPE);
    localparam int POS_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
    localparam int LIST_ID_BITS = $clog2(NUM_TYPES * REGS_PER_TYPE);
    localparam int STORE_AW   = LIST_ID_BITS + POS_BITS;
    localparam int STORE_DEPTH = NUM_TYPES * REGS_PER_TYPE * (2 ** POS_BITS);
    localparam int LIST_COUNT = NUM_TYPES * REGS_PER_TYPE;

    localparam int PADDR_BITS = 3;
    localparam logic [PADDR_BITS-1:0] ADDR_ZERO_INDEX  = 3'd0;
    localparam logic [PADDR_BITS-1:0] ADDR_ZERO_ENABLE = 3'd4;

    typedef enum logic [2:0] {
        OP_INSERT       = 3'd0,
        OP_REMOVE       = 3'd1,
        OP_REMOVE_FRONT = 3'd2,
        OP_CAN_READ     = 3'd3,
        OP_CAN_WRITE    = 3'd4,
        OP_FORWARD      = 3'd5
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    typedef struct packed {
        logic [2:0]            operation;
        logic [TYPE_BITS-1:0]  reg_class;
        logic [INDEX_BITS-1:0] reg_index;
        logic [SEQ_W-1:0]      seq_num;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]       status;
        logic             allowed;
        logic             forward_found;
        logic [SEQ_W-1:0] forward_seq;
    } t_out_beat;

endpackage

### design/register_writer_scoreboard_unit.sv
// Writer scoreboard: per register of three classes, an oldest-first list of in-flight writer
// sequence numbers in one RAM, counts in a second. One item at a time: insert, check and
// untracked items read the count and list head, then give the output beat; remove-front and
// remove walk and shift the list through the single store write port; forward queries
// read one entry per cycle. The output beat is held while the output is stalled.
// Config via APB at 0x0 and 0x4.
module register_writer_scoreboard_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rws_pkg::t_in_beat    i_beat,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rws_pkg::t_out_beat   o_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rws_pkg::*;

    logic [5:0] r_zero_index;
    logic       r_zero_enable;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_index <= '0;
            r_zero_enable <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_ZERO_INDEX) begin
                r_zero_index <= pwdata[5:0];
            end else if (paddr == ADDR_ZERO_ENABLE) begin
                r_zero_enable <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ZERO_INDEX) begin
            prdata = {26'd0, r_zero_index};
        end else if (paddr == ADDR_ZERO_ENABLE) begin
            prdata = {31'd0, r_zero_enable};
        end
    end

    rws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_beat(i_beat),
        .o_valid(o_valid), .i_stall(i_stall), .o_beat(o_beat),
        .i_zero_index(r_zero_index), .i_zero_enable(r_zero_enable)
    );
endmodule

### design/rws_ram.sv
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/rws_ctrl.sv
module rws_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rws_pkg::t_in_beat    i_beat,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rws_pkg::t_out_beat   o_beat,
    input  logic [5:0]           i_zero_index,
    input  logic                 i_zero_enable
);
    import rws_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_READ   = 8'b00000010,
        S_CNT    = 8'b00000100,
        S_SCAN   = 8'b00001000,
        S_SHIFT  = 8'b00010000,
        S_SHWR   = 8'b00100000,
        S_FINISH = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_in_beat r_item, n_item;
    t_out_beat r_res, n_res;
    logic [CNT_BITS-1:0] r_n, n_n;
    logic [POS_BITS-1:0] r_pos, n_pos;

    logic [LIST_ID_BITS-1:0] list_id;
    logic [SEQ_W-1:0] seq_m;
    logic cnt_we, st_we;
    logic [CNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic [POS_BITS-1:0] st_wpos, st_rpos;
    logic [SEQ_W-1:0] st_wdata, st_rdata;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic untracked, acc;
    logic [CNT_BITS-1:0] n_eff;

    assign list_id = LIST_ID_BITS'(r_item.reg_class) * LIST_ID_BITS'(REGS_PER_TYPE)
                   + LIST_ID_BITS'(r_item.reg_index[REG_AW-1:0]);
    assign seq_m = i_beat.seq_num & SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);
    assign st_waddr = {list_id, st_wpos};
    assign st_raddr = {list_id, st_rpos};

    rws_ram #(.WIDTH(CNT_BITS), .DEPTH(LIST_COUNT)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(list_id), .i_wdata(cnt_wdata),
        .i_raddr(list_id), .o_rdata(cnt_rdata)
    );

    rws_ram #(.WIDTH(SEQ_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    // Counts come from a RAM with no reset; a valid bit per list stands in for zero.
    logic [LIST_COUNT-1:0] r_cvalid;
    logic r_cvld_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (cnt_we) begin
            r_cvalid[list_id] <= 1'b1;
        end
        r_cvld_q <= r_cvalid[list_id];
    end
    assign n_eff = r_cvld_q ? ((cnt_rdata > CNT_BITS'(LIST_DEPTH))
                               ? CNT_BITS'(LIST_DEPTH) : cnt_rdata) : '0;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_beat = r_res;

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_res = r_res;
        n_n = r_n;
        n_pos = r_pos;
        cnt_we = 1'b0;
        cnt_wdata = '0;
        st_we = 1'b0;
        st_wpos = '0;
        st_wdata = r_item.seq_num;
        st_rpos = r_pos;
        untracked = (r_item.reg_class == TYPE_BITS'(NUM_TYPES))
                 || (32'(r_item.reg_index) >= REGS_PER_TYPE)
                 || (r_item.reg_class == '0 && i_zero_enable
                     && r_item.reg_index == i_zero_index);
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_item = i_beat;
                    n_item.seq_num = seq_m;
                    n_res = '0;
                    n_pos = '0;
                    n_state = S_READ;
                    if (i_beat.operation > 3'(OP_FORWARD)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_READ: begin
                // count and head reads issued for the new list
                n_state = S_CNT;
            end
            S_CNT: begin
                // count and head are valid this cycle
                n_n = n_eff;
                if (untracked) begin
                    n_res.status = ST_IGNORED;
                    n_res.allowed = (r_item.operation == 3'(OP_CAN_READ))
                                 || (r_item.operation == 3'(OP_CAN_WRITE));
                    n_state = S_OUT;
                end else begin
                    case (r_item.operation)
                        3'(OP_INSERT): begin
                            if (n_eff >= CNT_BITS'(LIST_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                st_we = 1'b1;
                                st_wpos = n_eff[POS_BITS-1:0];
                                cnt_we = 1'b1;
                                cnt_wdata = n_eff + 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        3'(OP_REMOVE_FRONT): begin
                            if (n_eff == '0) begin
                                n_res.status = ST_NOT_FOUND;
                                n_state = S_OUT;
                            end else if (st_rdata != r_item.seq_num) begin
                                n_res.status = ST_MISMATCH;
                                n_state = S_OUT;
                            end else begin
                                n_pos = POS_BITS'(1);
                                n_state = (n_eff == CNT_BITS'(1)) ? S_FINISH : S_SHIFT;
                            end
                        end
                        3'(OP_CAN_READ), 3'(OP_CAN_WRITE): begin
                            n_res.allowed = (n_eff == '0) || (r_item.seq_num <= st_rdata);
                            n_state = S_OUT;
                        end
                        3'(OP_REMOVE): begin
                            n_res.status = ST_NOT_FOUND;
                            if (n_eff == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                                n_pos = '0;
                            end
                        end
                        default: begin
                            if (n_eff == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                                n_pos = '0;
                            end
                        end
                    endcase
                    if (r_item.operation == 3'(OP_FORWARD) ||
                        r_item.operation == 3'(OP_REMOVE)) begin
                        if (n_eff != '0) begin
                            st_rpos = '0;
                        end
                    end
                end
            end
            S_SCAN: begin
                // st_rdata is entry r_pos; next read issued for r_pos + 1
                st_rpos = r_pos + 1'b1;
                if (r_item.operation == 3'(OP_REMOVE)) begin
                    if (st_rdata == r_item.seq_num) begin
                        n_res.status = ST_OK;
                        if (CNT_BITS'(r_pos) + 1'b1 >= r_n) begin
                            n_state = S_FINISH;
                        end else begin
                            n_pos = r_pos + 1'b1;
                            n_state = S_SHIFT;
                        end
                    end else if (CNT_BITS'(r_pos) + 1'b1 >= r_n) begin
                        n_state = S_OUT;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end else begin
                    if (st_rdata < r_item.seq_num) begin
                        n_res.forward_found = 1'b1;
                        n_res.forward_seq = st_rdata;
                        if (CNT_BITS'(r_pos) + 1'b1 >= r_n) begin
                            n_state = S_OUT;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SHIFT: begin
                // read of entry r_pos in flight
                n_state = S_SHWR;
            end
            S_SHWR: begin
                st_we = 1'b1;
                st_wpos = r_pos - 1'b1;
                st_wdata = st_rdata;
                if (CNT_BITS'(r_pos) + 1'b1 >= r_n) begin
                    n_state = S_FINISH;
                end else begin
                    n_pos = r_pos + 1'b1;
                    st_rpos = r_pos + 1'b1;
                    n_state = S_SHIFT;
                end
            end
            S_FINISH: begin
                cnt_we = 1'b1;
                cnt_wdata = r_n - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SHIFT) begin
            st_rpos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_res <= n_res;
        r_n <= n_n;
        r_pos <= n_pos;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    a_no_double_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cnt_we && r_state == S_IDLE))
        else $error("count write when idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_res)))
        else $error("result dropped");
`endif
endmodule

### sim/register_writer_scoreboard_unit_tb.sv
module register_writer_scoreboard_unit_tb;
    import rws_pkg::*;

    localparam int MAX_CYCLES = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_beat    i_beat = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_beat   o_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    register_writer_scoreboard_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_beat(i_beat),
        .o_valid(o_valid), .i_stall(i_stall), .o_beat(o_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [SEQ_W-1:0] writers [NUM_TYPES][REGS_PER_TYPE][LIST_DEPTH];
    int               writer_cnt [NUM_TYPES][REGS_PER_TYPE];
    logic [5:0]       zero_idx;
    logic             zero_en;

    t_out_beat pending_results [$];
    int        errors = 0;
    int        cycles = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        hold_cycles = 0;
    bit        idle_rx = 1'b1;

    function automatic t_out_beat predict_scoreboard(t_in_beat b);
        t_out_beat r;
        int n;
        int pos;
        int t;
        int x;
        r = '0;
        t = b.reg_class;
        x = b.reg_index;
        if (b.operation > OP_FORWARD) return r;
        if (t >= NUM_TYPES || x >= REGS_PER_TYPE || (t == 0 && zero_en && x == zero_idx)) begin
            r.status = ST_IGNORED;
            r.allowed = (b.operation == OP_CAN_READ || b.operation == OP_CAN_WRITE);
            return r;
        end
        n = writer_cnt[t][x];
        pos = -1;
        case (b.operation)
            OP_INSERT: begin
                if (n >= LIST_DEPTH) r.status = ST_FULL;
                else begin
                    writers[t][x][n] = b.seq_num;
                    writer_cnt[t][x] = n + 1;
                end
            end
            OP_REMOVE: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < n; i++)
                    if (pos < 0 && writers[t][x][i] == b.seq_num) pos = i;
                if (pos >= 0) r.status = ST_OK;
            end
            OP_REMOVE_FRONT: begin
                if (n == 0) r.status = ST_NOT_FOUND;
                else if (writers[t][x][0] != b.seq_num) r.status = ST_MISMATCH;
                else pos = 0;
            end
            OP_CAN_READ, OP_CAN_WRITE: begin
                r.allowed = (n == 0 || b.seq_num <= writers[t][x][0]);
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    if (writers[t][x][i] >= b.seq_num) break;
                    r.forward_found = 1'b1;
                    r.forward_seq = writers[t][x][i];
                end
            end
        endcase
        if (pos >= 0) begin
            for (int i = pos; i + 1 < n; i++) writers[t][x][i] = writers[t][x][i + 1];
            writer_cnt[t][x] = n - 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("register_writer_scoreboard_unit regression: fail");
            $finish;
        end
    end

    // receiver: checks each result beat, random stalls plus one long hold
    always @(posedge i_clk) begin
        t_out_beat exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_beat.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_beat.status);
                    errors++;
                end
                if (o_beat.allowed !== exp_r.allowed) begin
                    $error("allowed expected %0d actual %0d", exp_r.allowed, o_beat.allowed);
                    errors++;
                end
                if (o_beat.forward_found !== exp_r.forward_found) begin
                    $error("forward_found expected %0d actual %0d",
                           exp_r.forward_found, o_beat.forward_found);
                    errors++;
                end
                if (o_beat.forward_seq !== exp_r.forward_seq) begin
                    $error("forward_seq expected %0h actual %0h",
                           exp_r.forward_seq, o_beat.forward_seq);
                    errors++;
                end
            end
        end
    end

    int rx_wait = 0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (idle_rx) begin
            i_stall <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && $urandom_range(0, 3) == 0) rx_wait <= $urandom_range(0, 18);
        end
    end

    task automatic send_beat(input t_in_beat b, input int gap);
        repeat (gap + 1) @(negedge i_clk);
        i_beat <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results = {pending_results, predict_scoreboard(b)};
        items_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    function automatic t_in_beat make_beat(t_op op, int t, int x, int s);
        t_in_beat b;
        b.operation = op;
        b.reg_class = TYPE_BITS'(t);
        b.reg_index = INDEX_BITS'(x);
        b.seq_num = SEQ_W'(s);
        return b;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_zero_reg(input int idx, input bit en);
        drain();
        apb_write(ADDR_ZERO_INDEX, idx);
        apb_write(ADDR_ZERO_ENABLE, 32'(en));
        zero_idx = 6'(idx);
        zero_en = en;
    endtask

    task automatic test_directed();
        idle_rx = 1'b1;
        send_beat(make_beat(OP_CAN_READ, 1, 5, 16'h0000), 0);
        send_beat(make_beat(OP_FORWARD, 1, 5, 16'hffff), 0);
        send_beat(make_beat(OP_REMOVE_FRONT, 1, 5, 0), 0);
        send_beat(make_beat(OP_REMOVE, 1, 5, 0), 0);
        for (int i = 0; i < 9; i++) send_beat(make_beat(OP_INSERT, 1, 5, 100 + 10 * i), 0);
        send_beat(make_beat(OP_CAN_WRITE, 1, 5, 99), 1);
        send_beat(make_beat(OP_CAN_WRITE, 1, 5, 101), 0);
        send_beat(make_beat(OP_FORWARD, 1, 5, 135), 0);
        send_beat(make_beat(OP_REMOVE_FRONT, 1, 5, 110), 0);
        send_beat(make_beat(OP_REMOVE_FRONT, 1, 5, 100), 0);
        send_beat(make_beat(OP_REMOVE, 1, 5, 140), 0);
        send_beat(make_beat(OP_REMOVE, 1, 5, 141), 0);
        send_beat(make_beat(OP_INSERT, 0, 0, 16'hffff), 0);
        send_beat(make_beat(OP_CAN_READ, 0, 0, 3), 0);
        send_beat(make_beat(OP_INSERT, 3, 63, 16'hffff), 0);
        send_beat(make_beat(OP_CAN_WRITE, 3, 2, 7), 0);
        send_beat(t_in_beat'({3'd6, 2'd2, 6'd63, 16'hffff}), 0);
        send_beat(t_in_beat'({3'd7, 2'd1, 6'd0, 16'h1234}), 0);
    endtask

    task automatic test_random(input int count);
        t_in_beat b;
        int pick;
        idle_rx = 1'b0;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            // small register window so lists fill up and match
            b.reg_class = (pick < 3) ? 2'd3 : TYPE_BITS'($urandom_range(0, 2));
            b.reg_index = (pick < 8) ? INDEX_BITS'($urandom_range(0, 63))
                                     : INDEX_BITS'($urandom_range(0, 3));
            b.seq_num = (pick < 10) ? SEQ_W'($urandom_range(0, 65535))
                                    : SEQ_W'($urandom_range(0, 40));
            if (pick < 35) b.operation = OP_INSERT;
            else if (pick < 97) b.operation = 3'($urandom_range(1, 5));
            else b.operation = 3'($urandom_range(6, 7));
            send_beat(b, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 20; k++)
            send_beat(make_beat(OP_INSERT, 2, k % 4, $urandom_range(0, 65535)), 0);
    endtask

    initial begin
        for (int t = 0; t < NUM_TYPES; t++)
            for (int x = 0; x < REGS_PER_TYPE; x++) writer_cnt[t][x] = 0;
        zero_idx = '0;
        zero_en = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        set_zero_reg(63, 1'b1);
        test_random(150);
        test_backpressure();
        set_zero_reg(0, 1'b0);
        test_random(170);
        set_zero_reg(2, 1'b1);
        test_random(170);
        idle_rx = 1'b1;
        drain();
        $display("covered %0d items, %0d results, four zero-register settings, long hold-off",
                 items_sent, results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("register_writer_scoreboard_unit regression: pass");
        else
            $display("register_writer_scoreboard_unit regression: fail");
        $finish;
    end
endmodule
